// ----- sv/assert_macros.svh -----
// Assertion macros shared by the trapezoidal motion profiler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("motion profiler assertion failed");

// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("motion profiler assertion failed");

`endif

// ----- sv/tmp_pkg.sv -----
// Shared types and constants for the trapezoidal motion profiler.
// No dependencies; used by every module of the block but tmp_ram.
package tmp_pkg;

	localparam int CHANNELS_DEF = 5;

	localparam int CH_W    = 3;
	localparam int ANG_W   = 24;
	localparam int VEL_W   = 20;
	localparam int DUTY_W  = 25;
	localparam int MAXV_W  = 18;
	localparam int ACC_W   = 22;
	localparam int PF_W    = 16;
	localparam int DB_W    = 16;
	localparam int DC_W    = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_FULL = 3'd5;

	localparam logic [MAXV_W-1:0] MAX_VEL_RST   = 18'd25600;
	localparam logic [ACC_W-1:0]  MAX_ACC_RST   = 22'd51200;
	localparam logic [PF_W-1:0]   PERIOD_RST    = 16'd655;
	localparam logic [DB_W-1:0]   DEADBAND_RST  = 16'd3;
	localparam logic [DC_W-1:0]   DUTY_ZERO_RST = 16'd1638;
	localparam logic [DC_W-1:0]   DUTY_FULL_RST = 16'd8192;

	// error magnitude, sqrt radicand 2*acc*|e| and root
	localparam int ERR_W  = ANG_W + 1;
	localparam int RAD_W  = 48;
	localparam int ROOT_W = RAD_W / 2;

	// duty = trunc(deg*span / DIVISOR), DIVISOR = 4 * 45
	// |deg*span| < 2^31, so (n >> 2) < 2^29 and ceil(2^35 / 45) gives exact quotients
	localparam int DIVISOR     = 180;
	localparam int DIVN_W      = 32;
	localparam int DIVX_W      = 29;
	localparam int DIV_SH      = 35;
	localparam int DIV_RECIP_W = 30;
	localparam int DIV_RECIP   = 763549742;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// ----- sv/trapezoidal_motion_profiler_unit.sv -----
// Trapezoidal motion profiler top level; depends on tmp_pkg, tmp_ram, tmp_sqrt, tmp_cdiv.
// Set-target transaction: accepted while the sequencer is idle, no result.
// Tick: per channel, RAM read, load, deadband check, outside the deadband square root and
// velocity/position steps, then duty divide and RAM read-modify-write, for every channel in turn.
// Reset (arst_n low, asynchronous): registers to defaults, all channel state reads as zero
// through per-entry valid bits; no clearing pass.
module trapezoidal_motion_profiler_unit #(
	parameter int CHANNELS = tmp_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // channel, target_angle
	input  logic                            s_axis_tuser,  // kind
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [71:0]                     m_axis_tdata,  // channel_res, angle, velocity, duty
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tmp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	`include "assert_macros.svh"

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ANG_W = tmp_pkg::ANG_W;
	localparam int VEL_W = tmp_pkg::VEL_W;
	localparam int ERR_W = tmp_pkg::ERR_W;
	localparam int ST_W  = ANG_W + VEL_W;
	localparam int DUTY_W_L = tmp_pkg::DUTY_W;
	localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_LD   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_SQ   = 4'd4;
	localparam logic [3:0] S_VEL  = 4'd5;
	localparam logic [3:0] S_INC  = 4'd6;
	localparam logic [3:0] S_POS  = 4'd7;
	localparam logic [3:0] S_DMUL = 4'd8;
	localparam logic [3:0] S_DIV  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	// configuration
	logic [tmp_pkg::MAXV_W-1:0] max_vel_q;
	logic [tmp_pkg::ACC_W-1:0]  max_acc_q;
	logic [tmp_pkg::PF_W-1:0]   period_q;
	logic [tmp_pkg::DB_W-1:0]   deadband_q;
	logic [tmp_pkg::DC_W-1:0]   duty_zero_q;
	logic [tmp_pkg::DC_W-1:0]   duty_full_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vel_q   <= tmp_pkg::MAX_VEL_RST;
			max_acc_q   <= tmp_pkg::MAX_ACC_RST;
			period_q    <= tmp_pkg::PERIOD_RST;
			deadband_q  <= tmp_pkg::DEADBAND_RST;
			duty_zero_q <= tmp_pkg::DUTY_ZERO_RST;
			duty_full_q <= tmp_pkg::DUTY_FULL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tmp_pkg::REG_MAX_VEL:   max_vel_q   <= cfg_data[tmp_pkg::MAXV_W-1:0];
				tmp_pkg::REG_MAX_ACC:   max_acc_q   <= cfg_data[tmp_pkg::ACC_W-1:0];
				tmp_pkg::REG_PERIOD:    period_q    <= cfg_data[tmp_pkg::PF_W-1:0];
				tmp_pkg::REG_DEADBAND:  deadband_q  <= cfg_data[tmp_pkg::DB_W-1:0];
				tmp_pkg::REG_DUTY_ZERO: duty_zero_q <= cfg_data[tmp_pkg::DC_W-1:0];
				tmp_pkg::REG_DUTY_FULL: duty_full_q <= cfg_data[tmp_pkg::DC_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [tmp_pkg::CH_W-1:0] in_ch;
	logic [ANG_W-1:0]         in_tgt;
	logic                     s_fire;
	logic                     in_range;

	assign in_ch    = s_axis_tdata[tmp_pkg::CH_W-1:0];
	assign in_tgt   = s_axis_tdata[tmp_pkg::CH_W +: ANG_W];
	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign in_range = (32'(in_ch) < 32'(CHANNELS));

	logic [3:0]    state_q;
	logic [AW-1:0] ch_q;

	assign s_axis_tready = (state_q == S_IDLE);

	// memories
	logic                tgt_we;
	logic [ANG_W-1:0]    tgt_rd;
	logic                st_we;
	logic [ST_W-1:0]     st_rd;
	logic [CHANNELS-1:0] tgt_vld_q;
	logic [CHANNELS-1:0] st_vld_q;
	logic                out_load;

	logic signed [ANG_W-1:0] tgt_q;
	logic signed [ANG_W-1:0] pos_q;
	logic signed [VEL_W-1:0] vel_q;
	logic signed [ANG_W-1:0] pnew_q;
	logic signed [VEL_W-1:0] vnew_q;

	assign tgt_we = s_fire && !s_axis_tuser && in_range;
	assign st_we  = out_load;

	tmp_ram #(.WIDTH(ANG_W), .DEPTH(CHANNELS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (AW'(in_ch)),
		.wdata (in_tgt),
		.raddr (ch_q),
		.rdata (tgt_rd)
	);

	tmp_ram #(.WIDTH(ST_W), .DEPTH(CHANNELS)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (ch_q),
		.wdata ({pnew_q, vnew_q}),
		.raddr (ch_q),
		.rdata (st_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_vld_q <= '0;
			st_vld_q  <= '0;
		end else begin
			if (tgt_we) begin
				tgt_vld_q[AW'(in_ch)] <= 1'b1;
			end
			if (st_we) begin
				st_vld_q[ch_q] <= 1'b1;
			end
		end
	end

	// compute datapath
	logic                     eneg_q;
	logic [ERR_W-1:0]         ae_q;
	logic [tmp_pkg::ACC_W-1:0] dv_q;
	logic signed [VEL_W-1:0]  tv_q;
	logic [VEL_W:0]           inc_q;
	logic                     dneg_q;

	logic signed [ANG_W-1:0]  ld_tgt;
	logic signed [ANG_W-1:0]  ld_pos;
	logic signed [ERR_W-1:0]  err;
	logic                     in_db;
	logic                     sq_start;
	logic [tmp_pkg::RAD_W-1:0] radicand;
	tmp_pkg::unit_sts_t       sq_sts;
	logic [tmp_pkg::ROOT_W-1:0] root;
	logic [tmp_pkg::ROOT_W-1:0] spd;
	logic [37:0]              dv_prod;

	logic signed [VEL_W:0]    ve;
	logic [VEL_W:0]           ave;
	logic signed [VEL_W+2:0]  v_step;
	logic [VEL_W-1:0]         av;
	logic [VEL_W+tmp_pkg::PF_W:0] inc_full;
	logic signed [ANG_W+1:0]  p_sum;

	logic signed [15:0]       deg;
	logic signed [16:0]       span;
	logic signed [32:0]       dprod;
	logic [32:0]              dmag;
	logic                     dv_start;
	tmp_pkg::unit_sts_t       dv_sts;
	logic [tmp_pkg::DIVN_W-1:0] quot;
	logic [DUTY_W_L-1:0]      duty;

	always_comb begin
		ld_tgt   = tgt_vld_q[ch_q] ? tgt_rd : '0;
		ld_pos   = st_vld_q[ch_q] ? st_rd[ST_W-1 -: ANG_W] : '0;
		err      = {ld_tgt[ANG_W-1], ld_tgt} - {ld_pos[ANG_W-1], ld_pos};
		in_db    = (ae_q <= ERR_W'(deadband_q));
		sq_start = (state_q == S_CHK) && !in_db;
		radicand = {(tmp_pkg::RAD_W - 1)'(max_acc_q) * (tmp_pkg::RAD_W - 1)'(ae_q), 1'b0};
		dv_prod  = max_acc_q * period_q;
		spd      = (root < tmp_pkg::ROOT_W'(max_vel_q)) ? root
		           : tmp_pkg::ROOT_W'(max_vel_q);

		ve  = {tv_q[VEL_W-1], tv_q} - {vel_q[VEL_W-1], vel_q};
		ave = ve[VEL_W] ? -ve : ve;
		if ({1'b0, ave} > (VEL_W + 2)'(dv_q)) begin
			v_step = ve[VEL_W] ? ((VEL_W + 3)'(vel_q) - $signed({1'b0, dv_q}))
			                   : ((VEL_W + 3)'(vel_q) + $signed({1'b0, dv_q}));
		end else begin
			v_step = (VEL_W + 3)'(tv_q);
		end

		av       = vnew_q[VEL_W-1] ? VEL_W'(-vnew_q) : VEL_W'(vnew_q);
		inc_full = (VEL_W + tmp_pkg::PF_W + 1)'(av) * period_q + 37'd32768;

		p_sum = vnew_q[VEL_W-1] ? ((ANG_W + 2)'(pos_q) - $signed({5'b0, inc_q}))
		                        : ((ANG_W + 2)'(pos_q) + $signed({5'b0, inc_q}));

		deg      = 16'(pnew_q >>> 8) + 16'((pnew_q[ANG_W-1] && (pnew_q[7:0] != 8'd0)) ? 1 : 0);
		span     = $signed({1'b0, duty_full_q}) - $signed({1'b0, duty_zero_q});
		dprod    = deg * span;
		dmag     = dprod[32] ? 33'(-dprod) : 33'(dprod);
		dv_start = (state_q == S_DMUL);

		duty = (dneg_q ? -DUTY_W_L'(quot[DUTY_W_L-2:0]) : DUTY_W_L'(quot[DUTY_W_L-2:0]))
		       + DUTY_W_L'(duty_zero_q);
	end

	tmp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.sts      (sq_sts),
		.root     (root)
	);

	tmp_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.numer  (dmag[tmp_pkg::DIVN_W-1:0]),
		.sts    (dv_sts),
		.quot   (quot)
	);

	assign out_load = (state_q == S_OUT) && (!m_axis_tvalid || m_axis_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_fire && s_axis_tuser) begin
						ch_q    <= '0;
						state_q <= S_RD;
					end
				end
				S_RD:   state_q <= S_LD;
				S_LD:   state_q <= S_CHK;
				S_CHK:  state_q <= in_db ? S_DMUL : S_SQ;
				S_SQ: begin
					if (sq_sts.done) begin
						state_q <= S_VEL;
					end
				end
				S_VEL:  state_q <= S_INC;
				S_INC:  state_q <= S_POS;
				S_POS:  state_q <= S_DMUL;
				S_DMUL: state_q <= S_DIV;
				S_DIV: begin
					if (dv_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (ch_q == LAST_CH) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LD: begin
				tgt_q  <= ld_tgt;
				pos_q  <= ld_pos;
				vel_q  <= st_vld_q[ch_q] ? st_rd[VEL_W-1:0] : '0;
				eneg_q <= err[ERR_W-1];
				ae_q   <= err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
			end
			S_CHK: begin
				dv_q <= dv_prod[37:16];
				if (in_db) begin
					vnew_q <= '0;
					pnew_q <= tgt_q;
				end
			end
			S_SQ: begin
				if (sq_sts.done) begin
					tv_q <= eneg_q ? -VEL_W'(spd) : VEL_W'(spd);
				end
			end
			S_VEL:  vnew_q <= VEL_W'(v_step);
			S_INC:  inc_q  <= inc_full[VEL_W+tmp_pkg::PF_W -: (VEL_W + 1)];
			S_POS: begin
				if (p_sum > (ANG_W + 2)'(2 ** (ANG_W - 1) - 1)) begin
					pnew_q <= {1'b0, {(ANG_W - 1){1'b1}}};
				end else if (p_sum < -(ANG_W + 2)'(2 ** (ANG_W - 1))) begin
					pnew_q <= {1'b1, {(ANG_W - 1){1'b0}}};
				end else begin
					pnew_q <= ANG_W'(p_sum);
				end
			end
			S_DMUL: dneg_q <= dprod[32];
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {duty, vnew_q, pnew_q, tmp_pkg::CH_W'(ch_q)};
			m_axis_tlast <= (ch_q == LAST_CH);
		end
	end

	`ASSERT_CLKRST(a_busy_ch_range, clk, arst_n, (state_q != S_IDLE) |-> (ch_q <= LAST_CH))
	`ASSERT_CLKRST(a_out_no_overrun, clk, arst_n, out_load |-> (!m_axis_tvalid || m_axis_tready))
	`ASSERT_CLKRST(a_tick_starts, clk, arst_n, (s_fire && s_axis_tuser) |=> (state_q == S_RD))
	`ASSERT_CLKRST(a_sqrt_done_in_sq, clk, arst_n, sq_sts.done |-> (state_q == S_SQ))
	`ASSERT_CLKRST(a_last_flag, clk, arst_n, (out_load && (ch_q == LAST_CH)) |=> m_axis_tlast)

endmodule

// ----- sv/tmp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/tmp_sqrt.sv -----
// Iterative integer square root, one root bit per cycle (floored).
// Depends on tmp_pkg.
module tmp_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tmp_pkg::RAD_W-1:0]   radicand,
	output tmp_pkg::unit_sts_t          sts,
	output logic [tmp_pkg::ROOT_W-1:0]  root
);

	localparam int RW  = tmp_pkg::ROOT_W;
	localparam int REM_W = RW + 2;
	localparam int SH_W  = RW + 4;
	localparam int CNT_W = $clog2(RW + 1);

	logic [tmp_pkg::RAD_W-1:0] rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [RW-1:0]             root_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [SH_W-1:0] rem_sh;
	logic [SH_W-1:0] trial;
	logic [SH_W-1:0] diff;
	logic            ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[tmp_pkg::RAD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		diff   = rem_sh - trial;
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[tmp_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(diff) : REM_W'(rem_sh);
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

// ----- sv/tmp_cdiv.sv -----
// Divide by the constant duty divisor: shift by two, then multiply by the reciprocal of 45.
// Registers: x_q on start, quo_q while busy, done follows busy. Depends on tmp_pkg.
module tmp_cdiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tmp_pkg::DIVN_W-1:0]  numer,
	output tmp_pkg::unit_sts_t          sts,
	output logic [tmp_pkg::DIVN_W-1:0]  quot
);

	localparam int NW = tmp_pkg::DIVN_W;
	localparam int XW = tmp_pkg::DIVX_W;
	localparam int MW = tmp_pkg::DIV_RECIP_W;
	localparam int PW = XW + MW;
	localparam int QW = PW - tmp_pkg::DIV_SH;

	localparam logic [MW-1:0] RECIP = MW'(tmp_pkg::DIV_RECIP);

	logic [XW-1:0] x_q;
	logic [NW-1:0] quo_q;
	logic          busy_q;
	logic          done_q;

	logic [PW-1:0] prod;

	always_comb begin
		prod = PW'(x_q) * PW'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= numer[XW+1:2];
		end
		if (busy_q) begin
			quo_q <= NW'(prod[PW-1 -: QW]);
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quo_q;

endmodule

// ----- test/tmp_checker.sv -----
// Checker for the trapezoidal motion profiler: watches the item, result and register channels,
// predicts each channel's angle, velocity and duty per tick, and counts mismatches.
// Depends on tmp_pkg.
module tmp_checker import tmp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [31:0]           s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [71:0]           m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    result_count
);
	localparam int NCH = CHANNELS_DEF;
	localparam longint ANG_HI = 64'sd8388607;
	localparam longint ANG_LO = -64'sd8388608;

	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [ANG_W-1:0]  angle;
		logic [VEL_W-1:0]  vel;
		logic [DUTY_W-1:0] duty;
		logic              last;
	} servo_state_t;

	servo_state_t expected_q[$];

	longint speed_limit, accel_limit, period_q16, snap_band, duty_lo, duty_hi;
	longint target_pos[NCH];
	longint cur_pos[NCH];
	longint cur_vel[NCH];

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic profile_tick();
		longint e, ae, spd, tv, dv, v, ve, ave, inc, p, deg, dty;
		servo_state_t s;
		for (int c = 0; c < NCH; c++) begin
			e = target_pos[c] - cur_pos[c];
			ae = e < 0 ? -e : e;
			if (ae <= snap_band) begin
				cur_vel[c] = 0;
				cur_pos[c] = target_pos[c];
			end else begin
				spd = longint'(floor_sqrt(2 * accel_limit * ae));
				if (spd > speed_limit) spd = speed_limit;
				tv = e > 0 ? spd : -spd;
				dv = (accel_limit * period_q16) >>> 16;
				v = cur_vel[c];
				ve = tv - v;
				ave = ve < 0 ? -ve : ve;
				if (ave > dv) v += ve > 0 ? dv : -dv;
				else v = tv;
				cur_vel[c] = v;
				inc = (((v < 0) ? -v : v) * period_q16 + 32768) >>> 16;
				p = cur_pos[c] + (v < 0 ? -inc : inc);
				if (p > ANG_HI) p = ANG_HI;
				if (p < ANG_LO) p = ANG_LO;
				cur_pos[c] = p;
			end
			deg = cur_pos[c] / 256;
			dty = deg * (duty_hi - duty_lo) / 180 + duty_lo;
			s.ch = c[CH_W-1:0];
			s.angle = cur_pos[c][ANG_W-1:0];
			s.vel = cur_vel[c][VEL_W-1:0];
			s.duty = dty[DUTY_W-1:0];
			s.last = (c == NCH - 1);
			expected_q.push_back(s);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		servo_state_t got, exp_s;
		if (!arst_n) begin
			speed_limit = MAX_VEL_RST;
			accel_limit = MAX_ACC_RST;
			period_q16 = PERIOD_RST;
			snap_band = DEADBAND_RST;
			duty_lo = DUTY_ZERO_RST;
			duty_hi = DUTY_FULL_RST;
			for (int c = 0; c < NCH; c++) begin
				target_pos[c] = 0;
				cur_pos[c] = 0;
				cur_vel[c] = 0;
			end
			expected_q.delete();
			fail_count = 0;
			result_count = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ch = m_axis_tdata[2:0];
				got.angle = m_axis_tdata[26:3];
				got.vel = m_axis_tdata[46:27];
				got.duty = m_axis_tdata[71:47];
				got.last = m_axis_tlast;
				result_count++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction: ch %0d angle %0d",
							got.ch, $signed(got.angle));
				end else begin
					exp_s = expected_q.pop_front();
					if (got !== exp_s) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp ch %0d ang %0d vel %0d duty %0d last %0d",
								" / got ch %0d ang %0d vel %0d duty %0d last %0d"},
								exp_s.ch, $signed(exp_s.angle), $signed(exp_s.vel),
								$signed(exp_s.duty), exp_s.last, got.ch,
								$signed(got.angle), $signed(got.vel),
								$signed(got.duty), got.last);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					profile_tick();
				else if (s_axis_tdata[2:0] < NCH)
					target_pos[s_axis_tdata[2:0]] = longint'($signed(s_axis_tdata[26:3]));
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_VEL:   speed_limit = cfg_data[MAXV_W-1:0];
					REG_MAX_ACC:   accel_limit = cfg_data[ACC_W-1:0];
					REG_PERIOD:    period_q16 = cfg_data[PF_W-1:0];
					REG_DEADBAND:  snap_band = cfg_data[DB_W-1:0];
					REG_DUTY_ZERO: duty_lo = cfg_data[DC_W-1:0];
					REG_DUTY_FULL: duty_hi = cfg_data[DC_W-1:0];
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end
endmodule

// ----- test/tb_top.sv -----
// Top of the motion profiler testbench: clock, reset, target/tick and register stimulus
// with random idling, and the verdict. Depends on tmp_pkg, the profiler RTL and tmp_checker.
module tb_top;
	import tmp_pkg::*;

	localparam int DRAIN_CYCLES = 260;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [71:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count, pending, result_count;
	int idle_pct, stall_pct, cycles, tick_count, target_count, reg_writes;

	trapezoidal_motion_profiler_unit DUT (.*);

	tmp_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic send_item(input logic kind, input logic [2:0] ch, input logic [23:0] ang);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {5'd0, ang, ch};
		do @(posedge clk); while (!s_axis_tready);
		if (kind) tick_count++;
		else target_count++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_regs(input int vmax, input int amax, input int per, input int band,
			input int dz, input int df);
		wait_idle();
		write_reg(REG_MAX_VEL, vmax);
		write_reg(REG_MAX_ACC, amax);
		write_reg(REG_PERIOD, per);
		write_reg(REG_DEADBAND, band);
		write_reg(REG_DUTY_ZERO, dz);
		write_reg(REG_DUTY_FULL, df);
	endtask

	task automatic random_item();
		logic [23:0] ang;
		logic [2:0] ch;
		ch = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		if ($urandom_range(1)) ang = 24'($signed($urandom_range(40000)) - 20000);
		else ang = 24'($urandom);
		if ($urandom_range(99) < 65) send_item(1'b1, 3'($urandom), 24'($urandom));
		else send_item(1'b0, ch, ang);
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tuser = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		tick_count = 0;
		target_count = 0;
		reg_writes = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes, ignored channels, deadband snap, default registers
		send_item(1'b0, 3'd0, 24'h7FFFFF);
		send_item(1'b0, 3'd1, 24'h800000);
		send_item(1'b0, 3'd2, 24'd2);
		send_item(1'b0, 3'd3, 24'd1000);
		send_item(1'b0, 3'd4, -24'sd1000);
		send_item(1'b0, 3'd5, 24'd123);
		send_item(1'b0, 3'd7, 24'hFFFFFF);
		repeat (3) send_item(1'b1, 3'd7, 24'hFFFFFF);
		// fastest motion: overshoot and saturation at both ends
		load_regs(262143, 4194303, 65535, 0, 65535, 0);
		repeat (4) send_item(1'b1, 3'd0, 24'd0);
		// stalled profile: zero speed and acceleration, wide deadband
		load_regs(0, 0, 1, 65535, 0, 65535);
		send_item(1'b0, 3'd2, 24'd70000);
		repeat (2) send_item(1'b1, 3'd0, 24'd0);
		load_regs(25600, 0, 30000, 3, 1638, 8192);
		send_item(1'b0, 3'd3, -24'sd500000);
		repeat (3) send_item(1'b1, 3'd0, 24'd0);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 75 : 30) : 0;
			stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 75 : 30) : 0;
			case (ph)
				0: load_regs(25600, 51200, 655, 3, 1638, 8192);
				1: load_regs(262143, 4194303, 65535, 0, 0, 65535);
				2: load_regs($urandom_range(262143), $urandom_range(4194303),
					$urandom_range(1, 65535), $urandom_range(200), $urandom_range(65535),
					$urandom_range(65535));
				default: load_regs($urandom_range(60000), $urandom_range(400000),
					$urandom_range(1, 8000), $urandom_range(65535), $urandom_range(65535),
					$urandom_range(65535));
			endcase
			for (int i = 0; i < 102; i++) begin
				random_item();
				if (i == 50) wait_idle();
			end
		end

		wait_idle();
		$display("covered %0d ticks, %0d target writes, %0d register writes, %0d results",
			tick_count, target_count, reg_writes, result_count);
		$display("phases: no idling, sender idle, receiver stall, both; extreme and random settings");
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("simulation failed");
		end
		$finish;
	end
endmodule
